// ===== sv/pls_pkg.sv =====
// Package for the Phong lighting shader: word layouts, register indexes,
// sequencer states, fixed-point helpers and the gamma threshold table.
// No dependencies.
package pls_pkg;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SHADE = 1'b1;

  typedef enum logic [2:0] {
    CFG_LIGHT_COUNT   = 3'd0,
    CFG_AMBIENT_COEFF = 3'd1,
    CFG_DIFFUSE_COEFF = 3'd2,
    CFG_SPEC_COEFF    = 3'd3,
    CFG_BASE_AMBIENT  = 3'd4,
    CFG_VIEWER_POS    = 3'd5,
    CFG_SHININESS     = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BASE, ST_SQ, ST_SQRT, ST_DSET, ST_DIV, ST_LRD, ST_LSET,
    ST_LN, ST_REFL, ST_RV, ST_SPEC, ST_CHAN, ST_GINIT, ST_GSTEP, ST_DONE
  } pls_state_e;

  typedef struct packed {
    logic               func;
    logic [2:0]         light_index;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [47:0]        light_ambient_rgb;
    logic [47:0]        light_diffuse_rgb;
    logic [47:0]        light_specular_rgb;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [47:0]        surface_normal;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [47:0] linear_color;
  } out_item_t;

  typedef struct packed {
    logic [47:0] pos;
    logic [47:0] amb;
    logic [47:0] dif;
    logic [47:0] spe;
  } light_entry_t;

  localparam logic [14:0] One14 = 15'd16384;

  function automatic logic [15:0] fld16(input logic [47:0] x, input logic [1:0] idx);
    logic [15:0] r;
    case (idx)
      2'd0:    r = x[15:0];
      2'd1:    r = x[31:16];
      2'd2:    r = x[47:32];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [16:0] sx17(input logic [15:0] x);
    return $signed({x[15], x});
  endfunction

  // Signed division by 2^14, rounding toward zero.
  function automatic logic signed [37:0] trunc14(input logic signed [37:0] x);
    logic [37:0] mag;
    mag = x[37] ? 38'(-x) : 38'(x);
    mag = mag >> 14;
    return x[37] ? -$signed(mag) : $signed(mag);
  endfunction

  // Entry k is the smallest 1.16 level c with c^5 * 255^11 >= k^11 * 2^80,
  // so the gamma output for c is the largest k whose entry does not exceed c.
  function automatic logic [255:0][16:0] gamma_table();
    logic [255:0][16:0] t;
    logic [175:0] p255, k11, lhs, c5;
    logic [17:0]  lo, hi, mid;
    int           i, k;
    t    = '0;
    p255 = 176'd1;
    for (i = 0; i < 11; i++) p255 = p255 * 176'd255;
    for (k = 0; k < 256; k++) begin
      k11 = 176'd1;
      for (i = 0; i < 11; i++) k11 = k11 * 176'(k);
      lhs = k11 << 80;
      lo  = 18'd0;
      hi  = 18'd65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        c5  = 176'd1;
        for (i = 0; i < 5; i++) c5 = c5 * 176'(mid);
        if (c5 * p255 >= lhs) hi = mid;
        else lo = mid + 18'd1;
      end
      t[k] = lo[16:0];
    end
    return t;
  endfunction

  localparam logic [255:0][16:0] GammaThr = gamma_table();

endpackage

// ===== sv/phong_lighting_shader.sv =====
// Phong shader over a light table. A load word writes a table entry. A shade
// word walks the lights, each with at most shininess specular power steps;
// one shared multiplier, a bit-serial square root and a restoring divider
// do the arithmetic.
// Words are handled one at a time; a finished result waits in the output
// register. Reset restores the register defaults; table entries are undefined until loaded.
module phong_lighting_shader
  import pls_pkg::*;
#(
  parameter int MAX_LIGHTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int IdxW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CntW = $clog2(MAX_LIGHTS + 1);

  // Configuration registers
  logic [3:0]  light_count_q;
  logic [47:0] amb_coeff_q, dif_coeff_q, spe_coeff_q, base_amb_q, viewer_pos_q;
  logic [7:0]  shininess_q;

  pls_state_e state_q, state_d;
  logic [1:0]      k_q, k_d, ch_q, ch_d;
  logic [4:0]      it_q, it_d;
  logic [2:0]      step_q, step_d;
  logic [CntW-1:0] light_q, light_d;
  logic            view_q, view_d;
  logic [7:0]      sh_cnt_q, sh_cnt_d;
  logic            out_valid_q;

  // Datapath registers
  light_entry_t       light_mem [MAX_LIGHTS];
  light_entry_t       rd_q;
  logic signed [15:0] p_q [3];
  logic signed [15:0] n_q [3];
  logic signed [16:0] d_q [3];
  logic signed [15:0] v_q [3];
  logic signed [15:0] l_q [3];
  logic signed [19:0] r_q [3];
  logic [33:0]        s_q;
  logic [61:0]        rad_q;
  logic [33:0]        rem_q;
  logic [30:0]        root_q;
  logic [44:0]        drem_q, dsh_q;
  logic [14:0]        quo_q;
  logic signed [37:0] acc_q;
  logic signed [17:0] ln_q;
  logic [16:0]        diff_q;
  logic [13:0]        rv_q;
  logic [14:0]        spec_q;
  logic [47:0]        sum_q [3];
  logic [7:0]         lo_q, hi_q;
  logic [7:0]         gam_q [3];
  out_item_t          out_q;
  logic signed [51:0] prod_q;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic               accept, shade_go, mem_we;
  logic [1:0]         idx3, kp;
  logic signed [37:0] prod38, acc_sum, rv_full;
  logic [33:0]        s_sum;
  logic               s_zero;
  logic [35:0]        rem_sh, trial;
  logic               sq_ge, div_ge;
  logic [14:0]        quo_next;
  logic [6:0]         nl7;
  logic               lights_done, rv_skip;
  logic [13:0]        spec_new;
  logic [7:0]         mid;
  logic               thr_ok;
  logic signed [15:0] pin [3];

  assign accept   = in_valid_i && in_ready_o;
  assign shade_go = accept && (in_item_i.func == FUNC_SHADE);
  assign idx3     = (k_q == 2'd3) ? 2'd2 : k_q;
  assign kp       = k_q - 2'd1;
  assign prod38   = prod_q[37:0];
  assign acc_sum  = ((k_q == 2'd1) ? 38'sd0 : acc_q) + prod38;
  assign s_sum    = ((k_q == 2'd1) ? 34'd0 : s_q) + prod_q[33:0];
  assign s_zero   = (s_sum == 34'd0);
  assign rem_sh   = {rem_q, rad_q[61:60]};
  assign trial    = {3'b000, root_q, 2'b01};
  assign sq_ge    = rem_sh >= trial;
  assign div_ge   = drem_q >= dsh_q;
  assign quo_next = {quo_q[13:0], div_ge};
  assign nl7      = (7'(light_count_q) > 7'(MAX_LIGHTS)) ? 7'(MAX_LIGHTS)
                                                         : 7'(light_count_q);
  assign lights_done = (7'(light_q) == nl7);
  assign rv_full  = trunc14(acc_sum);
  assign rv_skip  = (rv_full <= 38'sd0) || (rv_full >= 38'sd16384) || (shininess_q == 8'd0);
  assign spec_new = prod_q[27:14];
  assign mid      = 8'(({1'b0, lo_q} + {1'b0, hi_q} + 9'd1) >> 1);
  assign thr_ok   = GammaThr[mid] <= {1'b0, sum_q[ch_q][27:12]};
  assign pin[0]   = in_item_i.point_x;
  assign pin[1]   = in_item_i.point_y;
  assign pin[2]   = in_item_i.point_z;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (shade_go) state_d = ST_BASE;
      ST_BASE:  if (k_q == 2'd3) state_d = ST_SQ;
      ST_SQ: begin
        if (k_q == 2'd3) begin
          if (!s_zero) state_d = ST_SQRT;
          else state_d = view_q ? ST_LRD : ST_CHAN;
        end
      end
      ST_SQRT:  if (it_q == 5'd0) state_d = ST_DSET;
      ST_DSET:  state_d = ST_DIV;
      ST_DIV: begin
        if (it_q == 5'd0) begin
          if (k_q != 2'd2) state_d = ST_DSET;
          else state_d = view_q ? ST_LRD : ST_LN;
        end
      end
      ST_LRD:   state_d = lights_done ? ST_GINIT : ST_LSET;
      ST_LSET:  state_d = ST_SQ;
      ST_LN:    if (k_q == 2'd3) state_d = ST_REFL;
      ST_REFL:  if (k_q == 2'd3) state_d = ST_RV;
      ST_RV:    if (k_q == 2'd3) state_d = rv_skip ? ST_CHAN : ST_SPEC;
      ST_SPEC: begin
        if (k_q[0] && (sh_cnt_q == 8'd1 || spec_new == 14'd0)) state_d = ST_CHAN;
      end
      ST_CHAN:  if (step_q == 3'd5 && ch_q == 2'd2) state_d = ST_LRD;
      ST_GINIT: state_d = ST_GSTEP;
      ST_GSTEP: if (lo_q == hi_q && ch_q == 2'd2) state_d = ST_DONE;
                else if (lo_q == hi_q) state_d = ST_GINIT;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake, table write and multiplier operands
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    mem_we     = accept && (in_item_i.func == FUNC_LOAD)
              && (7'(in_item_i.light_index) < 7'(MAX_LIGHTS));
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_BASE: begin
        mul_a = $signed({18'd0, fld16(amb_coeff_q, idx3)});
        mul_b = $signed({2'd0, fld16(base_amb_q, idx3)});
      end
      ST_SQ: begin
        mul_a = 34'(d_q[idx3]);
        mul_b = 18'(d_q[idx3]);
      end
      ST_LN: begin
        mul_a = 34'(l_q[idx3]);
        mul_b = 18'(n_q[idx3]);
      end
      ST_REFL: begin
        mul_a = $signed({{15{ln_q[17]}}, ln_q, 1'b0});
        mul_b = 18'(n_q[idx3]);
      end
      ST_RV: begin
        mul_a = 34'(r_q[idx3]);
        mul_b = 18'(v_q[idx3]);
      end
      ST_SPEC: begin
        mul_a = $signed({19'd0, spec_q});
        mul_b = $signed({4'd0, rv_q});
      end
      ST_CHAN: begin
        case (step_q)
          3'd0: begin
            mul_a = $signed({18'd0, fld16(amb_coeff_q, ch_q)});
            mul_b = $signed({2'd0, fld16(rd_q.amb, ch_q)});
          end
          3'd1: begin
            mul_a = $signed({18'd0, fld16(dif_coeff_q, ch_q)});
            mul_b = $signed({2'd0, fld16(rd_q.dif, ch_q)});
          end
          3'd2: begin
            mul_a = $signed({2'd0, prod_q[31:0]});
            mul_b = $signed({1'b0, diff_q});
          end
          3'd3: begin
            mul_a = $signed({18'd0, fld16(spe_coeff_q, ch_q)});
            mul_b = $signed({2'd0, fld16(rd_q.spe, ch_q)});
          end
          3'd4: begin
            mul_a = $signed({2'd0, prod_q[31:0]});
            mul_b = $signed({3'd0, spec_q});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer counters
  always_comb begin
    k_d      = k_q;
    it_d     = it_q;
    ch_d     = ch_q;
    step_d   = step_q;
    light_d  = light_q;
    view_d   = view_q;
    sh_cnt_d = sh_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (shade_go) begin
          k_d     = 2'd0;
          light_d = '0;
          view_d  = 1'b1;
        end
      end
      ST_BASE, ST_LN, ST_REFL: k_d = (k_q == 2'd3) ? 2'd0 : k_q + 2'd1;
      ST_SQ: begin
        k_d = (k_q == 2'd3) ? 2'd0 : k_q + 2'd1;
        if (k_q == 2'd3) it_d = 5'd30;
      end
      ST_SQRT: it_d = it_q - 5'd1;
      ST_DSET: it_d = 5'd14;
      ST_DIV: begin
        it_d = it_q - 5'd1;
        if (it_q == 5'd0) k_d = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      ST_LSET: begin
        k_d    = 2'd0;
        view_d = 1'b0;
      end
      ST_RV: begin
        k_d = (k_q == 2'd3) ? 2'd0 : k_q + 2'd1;
        if (k_q == 2'd3) sh_cnt_d = shininess_q;
      end
      ST_SPEC: begin
        k_d = {1'b0, ~k_q[0]};
        if (k_q[0]) sh_cnt_d = sh_cnt_q - 8'd1;
      end
      ST_CHAN: begin
        step_d = (step_q == 3'd5) ? 3'd0 : step_q + 3'd1;
        if (step_q == 3'd5) begin
          ch_d = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
          if (ch_q == 2'd2) light_d = CntW'(light_q + 1'b1);
        end
      end
      ST_GSTEP: if (lo_q == hi_q) ch_d = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      k_q           <= '0;
      it_q          <= '0;
      ch_q          <= '0;
      step_q        <= '0;
      light_q       <= '0;
      view_q        <= 1'b0;
      sh_cnt_q      <= '0;
      out_valid_q   <= 1'b0;
      light_count_q <= '0;
      amb_coeff_q   <= '0;
      dif_coeff_q   <= '0;
      spe_coeff_q   <= '0;
      base_amb_q    <= '0;
      viewer_pos_q  <= '0;
      shininess_q   <= 8'd1;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      it_q     <= it_d;
      ch_q     <= ch_d;
      step_q   <= step_d;
      light_q  <= light_d;
      view_q   <= view_d;
      sh_cnt_q <= sh_cnt_d;
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LIGHT_COUNT:   light_count_q <= cfg_data_i[3:0];
          CFG_AMBIENT_COEFF: amb_coeff_q   <= cfg_data_i;
          CFG_DIFFUSE_COEFF: dif_coeff_q   <= cfg_data_i;
          CFG_SPEC_COEFF:    spe_coeff_q   <= cfg_data_i;
          CFG_BASE_AMBIENT:  base_amb_q    <= cfg_data_i;
          CFG_VIEWER_POS:    viewer_pos_q  <= cfg_data_i;
          CFG_SHININESS:     shininess_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // Light table. It is written only while idle and read only while shading,
  // so a read never meets a write to the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      light_mem[IdxW'(in_item_i.light_index)] <= '{
        pos: {in_item_i.light_z, in_item_i.light_y, in_item_i.light_x},
        amb: in_item_i.light_ambient_rgb,
        dif: in_item_i.light_diffuse_rgb,
        spe: in_item_i.light_specular_rgb};
    end
    if (state_q == ST_LRD && !lights_done) rd_q <= light_mem[IdxW'(light_q)];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (shade_go) begin
          for (int i = 0; i < 3; i++) begin
            p_q[i] <= pin[i];
            n_q[i] <= $signed(fld16(in_item_i.surface_normal, 2'(i)));
            d_q[i] <= sx17(fld16(viewer_pos_q, 2'(i))) - sx17(pin[i]);
          end
        end
      end
      ST_BASE: if (k_q != 2'd0) sum_q[kp] <= 48'(prod_q[31:0]);
      ST_SQ: begin
        s_q <= s_sum;
        if (k_q == 2'd3) begin
          rad_q  <= {s_sum, 28'd0};
          rem_q  <= '0;
          root_q <= '0;
          if (s_zero) begin
            // A zero-length vector: the view vector is zero, a light adds
            // only its ambient term.
            if (view_q) begin
              for (int i = 0; i < 3; i++) v_q[i] <= '0;
            end else begin
              diff_q <= '0;
              spec_q <= '0;
            end
          end
        end
      end
      ST_SQRT: begin
        rem_q  <= sq_ge ? 34'(rem_sh - trial) : 34'(rem_sh);
        root_q <= {root_q[29:0], sq_ge};
        rad_q  <= {rad_q[59:0], 2'b00};
      end
      ST_DSET: begin
        drem_q <= {(d_q[k_q][16] ? 17'(-d_q[k_q]) : 17'(d_q[k_q])), 28'd0};
        dsh_q  <= {root_q, 14'd0};
        quo_q  <= '0;
      end
      ST_DIV: begin
        if (div_ge) drem_q <= drem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_next;
        if (it_q == 5'd0) begin
          if (view_q) v_q[k_q] <= d_q[k_q][16] ? -$signed({1'b0, quo_next})
                                               : $signed({1'b0, quo_next});
          else l_q[k_q] <= d_q[k_q][16] ? -$signed({1'b0, quo_next})
                                        : $signed({1'b0, quo_next});
        end
      end
      ST_LSET: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= sx17(fld16(rd_q.pos, 2'(i))) - sx17(p_q[i]);
        end
      end
      ST_LN: begin
        acc_q <= acc_sum;
        if (k_q == 2'd3) begin
          ln_q   <= 18'(trunc14(acc_sum));
          diff_q <= acc_sum[37] ? 17'd0 : 17'(trunc14(acc_sum));
        end
      end
      ST_REFL: if (k_q != 2'd0) r_q[kp] <= 20'(trunc14(prod38)) - 20'(l_q[kp]);
      ST_RV: begin
        acc_q <= acc_sum;
        if (k_q == 2'd3) begin
          rv_q   <= rv_full[13:0];
          spec_q <= (rv_full <= 38'sd0) ? 15'd0 : One14;
        end
      end
      ST_SPEC: if (k_q[0]) spec_q <= 15'(spec_new);
      ST_CHAN: begin
        case (step_q)
          3'd1:    sum_q[ch_q] <= sum_q[ch_q] + 48'(prod_q[31:0]);
          3'd3:    sum_q[ch_q] <= sum_q[ch_q] + 48'(prod_q[48:14]);
          3'd5:    sum_q[ch_q] <= sum_q[ch_q] + 48'(prod_q[48:14]);
          default: ;
        endcase
      end
      ST_GINIT: begin
        lo_q <= (sum_q[ch_q][47:28] != 20'd0) ? 8'd255 : 8'd0;
        hi_q <= 8'd255;
      end
      ST_GSTEP: begin
        if (lo_q == hi_q) gam_q[ch_q] <= lo_q;
        else if (thr_ok) lo_q <= mid;
        else hi_q <= mid - 8'd1;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.red   <= gam_q[0];
          out_q.green <= gam_q[1];
          out_q.blue  <= gam_q[2];
          for (int i = 0; i < 3; i++) begin
            out_q.linear_color[16*i +: 16] <=
              (sum_q[i][47:32] != 16'd0) ? 16'hFFFF : sum_q[i][31:16];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_shade_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_go |=> state_q == ST_BASE)
    else $error("shade word did not start the sequence");
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DSET |-> root_q >= 31'd16384)
    else $error("vector length below one while normalising");
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && it_q == 5'd0) |-> quo_next <= One14)
    else $error("unit vector component above one");
  a_light_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LRD && !lights_done) |-> 7'(light_q) < 7'(MAX_LIGHTS))
    else $error("light index beyond table");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for phong_lighting_shader: a directed table, then random
// phases of light loads and shaded points, checked against a fixed-point predictor.
// Depends on pls_pkg and phong_lighting_shader.
module tb;
  import pls_pkg::*;

  typedef enum logic [0:0] { ROW_WORD, ROW_REGS } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    in_item_t         word;
    bit               typed;
    out_item_t        want;
    logic [6:0][47:0] regs;
  } row_t;

  localparam int WatchLimit = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // Mirror of the block's registers and light table.
  logic [6:0][47:0] regs_m;
  logic [47:0] pos_tab [8];
  logic [47:0] amb_tab [8];
  logic [47:0] dif_tab [8];
  logic [47:0] spe_tab [8];

  out_item_t colour_q [$];
  row_t      rows [$];
  int        errors = 0;
  int        quiet_cnt = 0;
  bit        quiet = 1'b0;
  int        ready_burst = 0;
  int        stalled = 0;

  phong_lighting_shader u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q14 unit vector; returns 0 for a zero-length vector.
  function automatic bit unit_vec(input longint d [3], output longint u [3]);
    longint unsigned s;
    longint len, c;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(d[i] * d[i]);
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (s == 0) return 1'b0;
    len = longint'(isqrt(s << 28));
    for (int i = 0; i < 3; i++) begin
      c = (d[i] * 268435456) / len;
      if (c > 16384) c = 16384;
      if (c < -16384) c = -16384;
      u[i] = c;
    end
    return 1'b1;
  endfunction

  function automatic longint dot_q14(input longint a [3], input longint b [3]);
    return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) / 16384;
  endfunction

  function automatic longint sfield(input logic [47:0] x, input int i);
    logic signed [15:0] f;
    f = x[16*i +: 16];
    return longint'(f);
  endfunction

  function automatic longint unsigned ufield(input logic [47:0] x, input int i);
    longint unsigned f;
    f = 0;
    f[15:0] = x[16*i +: 16];
    return f;
  endfunction

  // Largest k with (k/255)^11 <= (c/2^16)^5, saturating at 255 from 1.0 upwards.
  function automatic logic [7:0] gamma8(input longint unsigned s);
    logic [199:0] lhs, rhs;
    logic [16:0]  c;
    int lo, hi, mid;
    if (s >= (64'd1 << 28)) return 8'd255;
    c = 17'(s >> 12);
    rhs = 200'd1;
    for (int i = 0; i < 11; i++) rhs = rhs * 200'd255;
    for (int i = 0; i < 5; i++) rhs = rhs * 200'(c);
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 200'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 200'(mid);
      lhs = lhs << 80;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

  function automatic out_item_t shade_colour(input in_item_t w);
    longint p [3], n [3], d [3], v [3], l [3], r [3];
    longint ln, rv;
    longint unsigned sum [3], diff, spec, s, q;
    int nl;
    logic [7:0] g [3];
    out_item_t o;
    p[0] = longint'(w.point_x);
    p[1] = longint'(w.point_y);
    p[2] = longint'(w.point_z);
    for (int i = 0; i < 3; i++) begin
      n[i] = sfield(w.surface_normal, i);
      d[i] = sfield(regs_m[CFG_VIEWER_POS], i) - p[i];
    end
    void'(unit_vec(d, v));
    for (int ch = 0; ch < 3; ch++)
      sum[ch] = ufield(regs_m[CFG_AMBIENT_COEFF], ch) * ufield(regs_m[CFG_BASE_AMBIENT], ch);
    nl = int'(regs_m[CFG_LIGHT_COUNT][3:0]);
    if (nl > 8) nl = 8;
    for (int i = 0; i < nl; i++) begin
      diff = 0;
      spec = 0;
      for (int k = 0; k < 3; k++) d[k] = sfield(pos_tab[i], k) - p[k];
      if (unit_vec(d, l)) begin
        ln = dot_q14(l, n);
        for (int k = 0; k < 3; k++) r[k] = (2 * ln * n[k]) / 16384 - l[k];
        diff = ln < 0 ? 0 : longint'(ln);
        rv = dot_q14(r, v);
        if (rv <= 0) spec = 0;
        else if (rv >= 16384) spec = 16384;
        else begin
          s = 16384;
          for (int k = 0; k < int'(regs_m[CFG_SHININESS][7:0]); k++)
            s = (s * longint'(rv)) >> 14;
          spec = s;
        end
      end
      for (int ch = 0; ch < 3; ch++) begin
        sum[ch] += ufield(regs_m[CFG_AMBIENT_COEFF], ch) * ufield(amb_tab[i], ch);
        sum[ch] += (ufield(regs_m[CFG_DIFFUSE_COEFF], ch) * ufield(dif_tab[i], ch)
                    * diff) >> 14;
        sum[ch] += (ufield(regs_m[CFG_SPEC_COEFF], ch) * ufield(spe_tab[i], ch)
                    * spec) >> 14;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      q = sum[ch] >> 16;
      if (q > 64'hFFFF) q = 64'hFFFF;
      o.linear_color[16*ch +: 16] = q[15:0];
      g[ch] = gamma8(sum[ch]);
    end
    o.red   = g[0];
    o.green = g[1];
    o.blue  = g[2];
    return o;
  endfunction

  function automatic logic [47:0] rgb3(input logic [15:0] r, g, b);
    return {b, g, r};
  endfunction

  function automatic logic [47:0] moderate_rgb();
    if ($urandom_range(0, 4) == 0) return {$urandom(), 16'($urandom())};
    return rgb3(16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                16'($urandom_range(0, 16384)));
  endfunction

  function automatic logic [15:0] coord();
    if ($urandom_range(0, 5) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 400)) - 200);
  endfunction

  function automatic in_item_t load_word(input logic [2:0] idx, input logic [15:0] x, y, z,
                                         input logic [47:0] a, dd, s);
    in_item_t w;
    w = '0;
    w.func = FUNC_LOAD;
    w.light_index = idx;
    w.light_x = x;
    w.light_y = y;
    w.light_z = z;
    w.light_ambient_rgb = a;
    w.light_diffuse_rgb = dd;
    w.light_specular_rgb = s;
    // The shade fields are don't-care on a load; point_x and the normal get random bits.
    w.point_x = 16'($urandom());
    w.surface_normal = {$urandom(), 16'($urandom())};
    return w;
  endfunction

  function automatic in_item_t shade_word(input logic [15:0] x, y, z, input logic [47:0] nrm);
    in_item_t w;
    w = '0;
    w.func = FUNC_SHADE;
    w.light_index = 3'($urandom());
    w.light_x = 16'($urandom());
    w.light_ambient_rgb = {$urandom(), 16'($urandom())};
    w.point_x = x;
    w.point_y = y;
    w.point_z = z;
    w.surface_normal = nrm;
    return w;
  endfunction

  function automatic logic [47:0] rand_normal();
    if ($urandom_range(0, 3) == 0) return {$urandom(), 16'($urandom())};
    return rgb3(16'($signed($urandom_range(0, 32768)) - 16384),
                16'($signed($urandom_range(0, 32768)) - 16384),
                16'($signed($urandom_range(0, 32768)) - 16384));
  endfunction

  function automatic in_item_t rand_word();
    if ($urandom_range(0, 9) < 4)
      return load_word(3'($urandom()), coord(), coord(), coord(),
                       moderate_rgb(), moderate_rgb(), moderate_rgb());
    return shade_word(coord(), coord(), coord(), rand_normal());
  endfunction

  task automatic send(input in_item_t w);
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // The accepted word updates the table mirror or queues its colour.
  task automatic note_word(input in_item_t w, input bit typed, input out_item_t want);
    if (w.func == FUNC_LOAD) begin
      pos_tab[w.light_index] = {w.light_z, w.light_y, w.light_x};
      amb_tab[w.light_index] = w.light_ambient_rgb;
      dif_tab[w.light_index] = w.light_diffuse_rgb;
      spe_tab[w.light_index] = w.light_specular_rgb;
    end else begin
      colour_q.push_back(typed ? want : shade_colour(w));
    end
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Registers change only with the block idle and every colour delivered.
  task automatic write_regs(input logic [6:0][47:0] vals);
    in_valid <= 1'b0;
    wait (colour_q.size() == 0);
    @(posedge clk);
    repeat (16) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs_m = vals;
    regs_m[CFG_LIGHT_COUNT] = {44'd0, vals[CFG_LIGHT_COUNT][3:0]};
    regs_m[CFG_SHININESS]   = {40'd0, vals[CFG_SHININESS][7:0]};
  endtask

  function automatic logic [6:0][47:0] pack_regs(input logic [3:0] cnt,
                                                 input logic [47:0] ka, kd, ks, base, eye,
                                                 input logic [7:0] shin);
    logic [6:0][47:0] v;
    v[CFG_LIGHT_COUNT]   = {44'd0, cnt};
    v[CFG_AMBIENT_COEFF] = ka;
    v[CFG_DIFFUSE_COEFF] = kd;
    v[CFG_SPEC_COEFF]    = ks;
    v[CFG_BASE_AMBIENT]  = base;
    v[CFG_VIEWER_POS]    = eye;
    v[CFG_SHININESS]     = {40'd0, shin};
    return v;
  endfunction

  task automatic add_word(input in_item_t w, input bit typed, input out_item_t want);
    row_t r;
    r.kind  = ROW_WORD;
    r.word  = w;
    r.typed = typed;
    r.want  = want;
    r.regs  = '0;
    rows.push_back(r);
  endtask

  task automatic add_regs(input logic [6:0][47:0] v);
    row_t r;
    r.kind  = ROW_REGS;
    r.word  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.regs  = v;
    rows.push_back(r);
  endtask

  // Receiver stalls come in bursts; none once the quiet stretch starts.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_burst == 0) begin
      out_ready   <= ($urandom_range(0, 2) != 0);
      ready_burst <= $urandom_range(1, 9);
    end else begin
      ready_burst <= ready_burst - 1;
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (colour_q.size() == 0) begin
        $display("%0t: unexpected colour word %h", $time, out_item);
        errors++;
      end else begin
        out_item_t e;
        e = colour_q.pop_front();
        if (out_item.red !== e.red || out_item.green !== e.green ||
            out_item.blue !== e.blue || out_item.linear_color !== e.linear_color) begin
          $display("%0t: colour mismatch expected rgb %h %h %h lin %h, got rgb %h %h %h lin %h",
                   $time, e.red, e.green, e.blue, e.linear_color,
                   out_item.red, out_item.green, out_item.blue, out_item.linear_color);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stalled <= 0;
    else stalled <= stalled + 1;
    if (stalled >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_item_t zero_c, sat_c;
    logic [47:0] ones;
    int items, cnt;
    bit heavy;
    logic [7:0] shin;
    ones   = 48'hFFFF_FFFF_FFFF;
    zero_c = '0;
    sat_c  = '{red: 8'd255, green: 8'd255, blue: 8'd255, linear_color: 48'hFFFE_FFFE_FFFE};
    regs_m = pack_regs(4'd0, '0, '0, '0, '0, '0, 8'd1);

    // Directed: field extremes, zero-length light, eye on the point, count past the table.
    add_word(shade_word(16'h8000, 16'h8000, 16'h8000, 48'h8000_8000_8000), 1'b1, zero_c);
    add_word(shade_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 48'h7FFF_7FFF_7FFF), 1'b1, zero_c);
    add_word(load_word(3'd0, 16'h8000, 16'h8000, 16'h8000, ones, ones, ones), 1'b0, zero_c);
    add_word(load_word(3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0, '0, '0), 1'b0, zero_c);
    add_word(load_word(3'd2, 16'd0, 16'd0, 16'd0, rgb3(16'h4000, 16'h4000, 16'h4000),
                       rgb3(16'h4000, 16'h4000, 16'h4000), rgb3(16'h4000, 16'h4000, 16'h4000)),
             1'b0, zero_c);
    for (int i = 3; i < 8; i++)
      add_word(load_word(3'(i), coord(), coord(), coord(), moderate_rgb(), moderate_rgb(),
                         moderate_rgb()), 1'b0, zero_c);
    add_regs(pack_regs(4'd0, ones, '0, '0, ones, '0, 8'd1));
    add_word(shade_word(16'd0, 16'd0, 16'd0, 48'h0000_0000_4000), 1'b1, sat_c);
    add_regs(pack_regs(4'd8, rgb3(16'h1000, 16'h1000, 16'h1000),
                       rgb3(16'h4000, 16'h4000, 16'h4000), rgb3(16'h4000, 16'h4000, 16'h4000),
                       rgb3(16'h0800, 16'h0800, 16'h0800), rgb3(16'd0, 16'd0, 16'd100), 8'd0));
    add_word(shade_word(16'd0, 16'd0, 16'd0, 48'h4000_0000_0000), 1'b0, zero_c);
    add_word(shade_word(16'd0, 16'd0, 16'd100, 48'h4000_0000_0000), 1'b0, zero_c);
    add_word(shade_word(16'd10, 16'hFFEC, 16'd5, 48'h0000_4000_0000), 1'b0, zero_c);
    add_regs(pack_regs(4'd12, moderate_rgb(), moderate_rgb(), moderate_rgb(), moderate_rgb(),
                       rgb3(16'h8000, 16'h7FFF, 16'd0), 8'd255));
    add_word(shade_word(16'h7FFF, 16'h8000, 16'h8000, rand_normal()), 1'b0, zero_c);
    add_word(shade_word(16'd3, 16'd4, 16'd5, ones), 1'b0, zero_c);
    add_word(load_word(3'd7, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       {$urandom(), 16'($urandom())}, {$urandom(), 16'($urandom())},
                       {$urandom(), 16'($urandom())}), 1'b0, zero_c);
    add_word(shade_word(coord(), coord(), coord(), rand_normal()), 1'b0, zero_c);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGS) begin
        write_regs(rows[i].regs);
      end else begin
        send(rows[i].word);
        note_word(rows[i].word, rows[i].typed, rows[i].want);
        idle_gap();
      end
    end

    // Random phases; long exponents with many lights are kept to short phases.
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 1) begin
        cnt  = 15;
        shin = 8'd255;
        write_regs(pack_regs(4'd15, ones, ones, ones, ones, ones, 8'd255));
      end else if (ph == 2) begin
        cnt  = 0;
        shin = 8'd0;
        write_regs(pack_regs(4'd0, '0, '0, '0, '0, '0, 8'd0));
      end else begin
        cnt = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
          0:       shin = 8'd0;
          1:       shin = 8'($urandom_range(100, 255));
          default: shin = 8'($urandom_range(1, 6));
        endcase
        write_regs(pack_regs(4'(cnt), moderate_rgb(), moderate_rgb(), moderate_rgb(),
                             moderate_rgb(), rgb3(coord(), coord(), coord()), shin));
      end
      heavy = (shin > 8'd16) && (cnt > 2);
      items = heavy ? 15 : 75;
      if (ph == 14) quiet = 1'b1;
      @(posedge clk);
      for (int k = 0; k < items; k++) begin
        in_item_t w;
        w = rand_word();
        send(w);
        note_word(w, 1'b0, zero_c);
        idle_gap();
      end
    end

    in_valid <= 1'b0;
    wait (colour_q.size() == 0);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
